/* hdl/svm_pkg.sv */
package svm_pkg;

	localparam int VOICES       = 2;
	localparam int VIDX_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int VCNT_W       = $clog2(VOICES + 1);

	localparam int CLIP_W       = 7;
	localparam int CLIPS        = 1 << CLIP_W;
	localparam int SADDR_W      = 16;
	localparam int SAMPLE_DEPTH = 1 << SADDR_W;

	localparam int SMP_W        = 16;
	localparam int GAIN_W       = 10;
	localparam int CNT_W        = 16;
	localparam int BASE_W       = 16;
	localparam int LEN_W        = 17;
	localparam int BUSY_W       = 2;
	localparam int CFG_DATA_W   = 16;

	// Q2.8 product, truncated result and voice sum
	localparam int PROD_W       = SMP_W + GAIN_W + 1;
	localparam int SCL_W        = PROD_W - 8;
	localparam int SUM_W        = SCL_W + VIDX_W + 1;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic REG_GAIN     = 1'b0;
	localparam logic REG_COOLDOWN = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RST     = GAIN_W'(205);
	localparam logic [CNT_W-1:0]  COOLDOWN_RST = CNT_W'(15435);
	localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;

	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_DEFINE  = 2'd1,
		OP_TRIGGER = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_COOLDOWN = 2'd1,
		ST_NO_VOICE = 2'd2
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [SADDR_W-1:0]  addr;
		logic [SMP_W-1:0]    left;
		logic [SMP_W-1:0]    right;
		logic [CLIP_W-1:0]   clip;
		logic [BASE_W-1:0]   start;
		logic [LEN_W-1:0]    frames;
	} item_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [CNT_W-1:0]  cooldown;
	} cfg_t;

endpackage

/* hdl/sample_voice_mixer.sv */
// Stereo sample-playback mixer. Each request carries an op: load one stereo
// word into sample memory, define a clip (start address and length), trigger
// a clip on the lowest free voice subject to the cooldown, or run one frame
// tick that mixes all active voices at the programmed Q2.8 gain and returns
// the saturated 16-bit left and right sums. Every request gives exactly one
// result. Requests enter a two-entry queue, so the input side keeps taking
// requests while the mixer works or a result waits at the output. A tick
// walks the voices in turn, reading each voice's clip entry from the
// registered clip table and then its sample through the single read port of
// the sample memory; voices whose clip has run out are freed. Load, define
// and trigger requests wait while an earlier result sits unaccepted at the
// output; a tick starts anyway and holds its result until the output frees.
// The clip table keeps a valid bit per clip, so there is no clearing pass
// after reset; sample memory reads as undefined until written. Write gain
// and cooldown only while the block is idle.
module sample_voice_mixer import svm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [15:0]            mem_address,
	input  logic signed [15:0]     load_left,
	input  logic signed [15:0]     load_right,
	input  logic [6:0]             clip_index,
	input  logic [15:0]            clip_start,
	input  logic [16:0]            clip_frames,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [15:0]     mix_left,
	output logic signed [15:0]     mix_right,
	output logic [1:0]             status,
	output logic [1:0]             busy_voices
);

	cfg_t   cfg_q;
	logic   item_valid;
	item_t  item;
	logic   item_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain     <= GAIN_RST;
			cfg_q.cooldown <= COOLDOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN:     cfg_q.gain     <= cfg_data[GAIN_W-1:0];
				REG_COOLDOWN: cfg_q.cooldown <= cfg_data[CNT_W-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	svm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.mem_address (mem_address),
		.load_left   (load_left),
		.load_right  (load_right),
		.clip_index  (clip_index),
		.clip_start  (clip_start),
		.clip_frames (clip_frames),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop)
	);

	svm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mix_left    (mix_left),
		.mix_right   (mix_right),
		.status      (status),
		.busy_voices (busy_voices)
	);

	// a refused trigger carries a silent mix, as every non-tick result does
	a_refused_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DONE) |-> (mix_left == '0) && (mix_right == '0))
		else $error("refused request carries a non-zero mix");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DONE || status == ST_COOLDOWN || status == ST_NO_VOICE))
		else $error("result carries an unused status code");

	a_no_voice_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NO_VOICE) |-> (busy_voices == BUSY_W'(VOICES)))
		else $error("trigger refused while a voice was free");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> item_valid)
		else $error("mixer took a request from an empty queue");

endmodule

/* hdl/svm_ram.sv */
module svm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/svm_front.sv */
module svm_front import svm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [15:0]         mem_address,
	input  logic signed [15:0]  load_left,
	input  logic signed [15:0]  load_right,
	input  logic [6:0]          clip_index,
	input  logic [15:0]         clip_start,
	input  logic [16:0]         clip_frames,
	output logic                item_valid,
	output item_t               item,
	input  logic                item_pop
);

	item_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	item_t              in_item;

	assign in_ready   = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign item_valid = (count_q != '0);
	assign item       = queue_q[rd_ptr_q];

	// classify the request and fold indexes to the table sizes
	always_comb begin
		in_item.op     = op_t'(op);
		in_item.addr   = SADDR_W'(mem_address);
		in_item.left   = load_left;
		in_item.right  = load_right;
		in_item.clip   = CLIP_W'(clip_index);
		in_item.start  = clip_start;
		in_item.frames = clip_frames;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (item_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !item_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && item_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

/* hdl/svm_back.sv */
module svm_back import svm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                item_valid,
	input  item_t               item,
	output logic                item_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  mix_left,
	output logic signed [15:0]  mix_right,
	output logic [1:0]          status,
	output logic [1:0]          busy_voices
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLIP,
		S_ADDR,
		S_SAMP,
		S_ACC,
		S_DONE
	} state_t;

	state_t                    state_q;
	logic [VIDX_W-1:0]         vidx_q;
	logic [VOICES-1:0]         voice_on_q;
	logic [CLIP_W-1:0]         voice_clip_q [VOICES];
	logic [LEN_W-1:0]          voice_pos_q [VOICES];
	logic [CNT_W-1:0]          since_q;
	logic [CLIPS-1:0]          clip_vld_q;
	logic                      clip_rd_vld_q;
	logic signed [PROD_W-1:0]  prod_l_q;
	logic signed [PROD_W-1:0]  prod_r_q;
	logic signed [SUM_W-1:0]   sum_l_q;
	logic signed [SUM_W-1:0]   sum_r_q;
	logic                      out_valid_q;
	logic [15:0]               mix_l_q;
	logic [15:0]               mix_r_q;
	status_t                   status_q;
	logic [BUSY_W-1:0]         busy_q;

	logic                      out_free;
	logic                      res_load;
	logic                      free_found;
	logic [VIDX_W-1:0]         free_idx;
	logic [VCNT_W-1:0]         busy_cnt;
	logic                      last_voice;

	logic                      clip_wr_en;
	logic                      clip_rd_en;
	logic [BASE_W+LEN_W-1:0]   clip_rd_data;
	logic                      smp_wr_en;
	logic                      smp_rd_en;
	logic [SADDR_W-1:0]        smp_rd_addr;
	logic [2*SMP_W-1:0]        smp_rd_data;

	logic [BASE_W-1:0]         cur_base;
	logic [LEN_W-1:0]          cur_len;
	logic [LEN_W-1:0]          cur_pos;
	logic [LEN_W-1:0]          pos_next;
	logic [LEN_W:0]            addr_sum;
	logic                      hit;
	logic [PROD_W-1:0]         adj_l;
	logic [PROD_W-1:0]         adj_r;
	logic signed [SCL_W-1:0]   scaled_l;
	logic signed [SCL_W-1:0]   scaled_r;

	function automatic logic [15:0] sat16(input logic signed [SUM_W-1:0] v);
		logic [15:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[15:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[15:0];
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	assign out_free   = !out_valid_q || out_ready;
	assign last_voice = (vidx_q == VIDX_W'(VOICES - 1));

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		busy_cnt   = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (!voice_on_q[v]) begin
				free_found = 1'b1;
				free_idx   = VIDX_W'(v);
			end
		end
		for (int v = 0; v < VOICES; v++) begin
			busy_cnt = busy_cnt + VCNT_W'(voice_on_q[v]);
		end
	end

	assign item_pop = (state_q == S_IDLE) && item_valid && ((item.op == OP_TICK) || out_free);

	// a new result enters the output register on these cycles only
	assign res_load = (item_pop && (item.op != OP_TICK)) || ((state_q == S_DONE) && out_free);

	// voice lookup, address and truncation toward zero
	always_comb begin
		cur_base = clip_rd_vld_q ? clip_rd_data[LEN_W +: BASE_W] : '0;
		cur_len  = clip_rd_vld_q ? clip_rd_data[LEN_W-1:0] : '0;
		cur_pos  = voice_pos_q[vidx_q];
		pos_next = cur_pos + 1'b1;
		hit      = (cur_pos < cur_len);
		addr_sum = (LEN_W+1)'(cur_base) + (LEN_W+1)'(cur_pos);
		smp_rd_addr = SADDR_W'(addr_sum);
		adj_l    = prod_l_q + (prod_l_q[PROD_W-1] ? PROD_W'(255) : '0);
		adj_r    = prod_r_q + (prod_r_q[PROD_W-1] ? PROD_W'(255) : '0);
		scaled_l = adj_l[PROD_W-1:8];
		scaled_r = adj_r[PROD_W-1:8];
	end

	assign clip_wr_en = item_pop && (item.op == OP_DEFINE);
	assign clip_rd_en = (state_q == S_CLIP);
	assign smp_wr_en  = item_pop && (item.op == OP_LOAD);
	assign smp_rd_en  = (state_q == S_ADDR) && hit;

	svm_ram #(
		.WIDTH (BASE_W + LEN_W),
		.DEPTH (CLIPS)
	) u_clip_ram (
		.clk     (clk),
		.wr_en   (clip_wr_en),
		.wr_addr (item.clip),
		.wr_data ({item.start, item.frames}),
		.rd_en   (clip_rd_en),
		.rd_addr (voice_clip_q[vidx_q]),
		.rd_data (clip_rd_data)
	);

	svm_ram #(
		.WIDTH (2 * SMP_W),
		.DEPTH (SAMPLE_DEPTH)
	) u_sample_ram (
		.clk     (clk),
		.wr_en   (smp_wr_en),
		.wr_addr (item.addr),
		.wr_data ({item.right, item.left}),
		.rd_en   (smp_rd_en),
		.rd_addr (smp_rd_addr),
		.rd_data (smp_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			vidx_q        <= '0;
			voice_on_q    <= '0;
			for (int v = 0; v < VOICES; v++) begin
				voice_clip_q[v] <= '0;
				voice_pos_q[v]  <= '0;
			end
			since_q       <= COUNT_MAX;
			clip_vld_q    <= '0;
			clip_rd_vld_q <= 1'b0;
			prod_l_q      <= '0;
			prod_r_q      <= '0;
			sum_l_q       <= '0;
			sum_r_q       <= '0;
			out_valid_q   <= 1'b0;
			mix_l_q       <= '0;
			mix_r_q       <= '0;
			status_q      <= ST_DONE;
			busy_q        <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_pop) begin
						// a tick leaves the output register alone until it is done
						if (item.op != OP_TICK) begin
							mix_l_q <= '0;
							mix_r_q <= '0;
						end
						unique case (item.op)
							OP_LOAD: begin
								status_q <= ST_DONE;
								busy_q   <= BUSY_W'(busy_cnt);
							end
							OP_DEFINE: begin
								clip_vld_q[item.clip] <= 1'b1;
								status_q              <= ST_DONE;
								busy_q                <= BUSY_W'(busy_cnt);
							end
							OP_TRIGGER: begin
								if (since_q < cfg.cooldown) begin
									status_q <= ST_COOLDOWN;
									busy_q   <= BUSY_W'(busy_cnt);
								end else if (free_found) begin
									voice_on_q[free_idx]   <= 1'b1;
									voice_clip_q[free_idx] <= item.clip;
									voice_pos_q[free_idx]  <= '0;
									since_q                <= '0;
									status_q               <= ST_DONE;
									busy_q <= BUSY_W'({1'b0, busy_cnt} + 1'b1);
								end else begin
									status_q <= ST_NO_VOICE;
									busy_q   <= BUSY_W'(busy_cnt);
								end
							end
							OP_TICK: begin
								vidx_q  <= '0;
								sum_l_q <= '0;
								sum_r_q <= '0;
								state_q <= S_CLIP;
							end
						endcase
					end
				end
				S_CLIP: begin
					clip_rd_vld_q <= clip_vld_q[voice_clip_q[vidx_q]];
					if (voice_on_q[vidx_q]) begin
						state_q <= S_ADDR;
					end else if (last_voice) begin
						state_q <= S_DONE;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				S_ADDR: begin
					if (hit) begin
						// pos_next never exceeds the length, so free on reaching it
						voice_pos_q[vidx_q] <= pos_next;
						voice_on_q[vidx_q]  <= (pos_next < cur_len);
						state_q             <= S_SAMP;
					end else begin
						voice_on_q[vidx_q] <= 1'b0;
						if (last_voice) begin
							state_q <= S_DONE;
						end else begin
							vidx_q  <= vidx_q + 1'b1;
							state_q <= S_CLIP;
						end
					end
				end
				S_SAMP: begin
					prod_l_q <= $signed(smp_rd_data[SMP_W-1:0]) * $signed({1'b0, cfg.gain});
					prod_r_q <= $signed(smp_rd_data[2*SMP_W-1:SMP_W]) * $signed({1'b0, cfg.gain});
					state_q  <= S_ACC;
				end
				S_ACC: begin
					sum_l_q <= sum_l_q + SUM_W'(scaled_l);
					sum_r_q <= sum_r_q + SUM_W'(scaled_r);
					if (last_voice) begin
						state_q <= S_DONE;
					end else begin
						vidx_q  <= vidx_q + 1'b1;
						state_q <= S_CLIP;
					end
				end
				S_DONE: begin
					// hold the result until the output slot frees
					if (out_free) begin
						mix_l_q     <= sat16(sum_l_q);
						mix_r_q     <= sat16(sum_r_q);
						status_q    <= ST_DONE;
						busy_q      <= BUSY_W'(busy_cnt);
						if (since_q != COUNT_MAX) begin
							since_q <= since_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign mix_left    = mix_l_q;
	assign mix_right   = mix_r_q;
	assign status      = status_q;
	assign busy_voices = busy_q;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
	import svm_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 40;
	localparam int FULL_GAIN_ROW = 12;

	typedef struct packed {
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
		status_t                 status;
		logic [BUSY_W-1:0]       busy;
	} mix_t;

	typedef struct {
		item_t req;
		bit    typed;
		mix_t  want;
	} row_t;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index   = REG_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [1:0]            op          = OP_LOAD;
	logic [15:0]           mem_address = '0;
	logic signed [15:0]    load_left   = '0;
	logic signed [15:0]    load_right  = '0;
	logic [6:0]            clip_index  = '0;
	logic [15:0]           clip_start  = '0;
	logic [16:0]           clip_frames = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic signed [15:0]    mix_left;
	logic signed [15:0]    mix_right;
	logic [1:0]            status;
	logic [1:0]            busy_voices;

	sample_voice_mixer i_dut (.*);

	// mixer state as the block should hold it
	logic [2*SMP_W-1:0] sample_mem   [SAMPLE_DEPTH];
	bit                 word_written [SAMPLE_DEPTH];
	logic [BASE_W-1:0]  clip_origin  [CLIPS];
	logic [LEN_W-1:0]   clip_span    [CLIPS];
	bit                 voice_live   [VOICES];
	logic [CLIP_W-1:0]  voice_track  [VOICES];
	logic [LEN_W-1:0]   voice_at     [VOICES];
	logic [CNT_W-1:0]   ticks_since;
	logic [GAIN_W-1:0]  gain_now;
	logic [CNT_W-1:0]   cooldown_now;

	mix_t mix_due [$];
	int   idle_pct   = 7;
	int   mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int scaled(input logic signed [SMP_W-1:0] s);
		// integer division truncates toward zero, as the Q2.8 scaling does
		return (int'(s) * int'(gain_now)) / 256;
	endfunction

	function automatic logic signed [SMP_W-1:0] clamp16(input int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return SMP_W'(v);
	endfunction

	function automatic mix_t mix_step(input item_t r);
		mix_t               res;
		int                 sum_l;
		int                 sum_r;
		int                 v;
		logic [CLIP_W-1:0]  c;
		logic [LEN_W-1:0]   span;
		logic [SADDR_W-1:0] a;
		logic [2*SMP_W-1:0] w;
		res = '0;
		sum_l = 0;
		sum_r = 0;
		case (r.op)
		OP_LOAD: begin
			sample_mem[r.addr] = {r.right, r.left};
			word_written[r.addr] = 1'b1;
		end
		OP_DEFINE: begin
			clip_origin[r.clip] = r.start;
			clip_span[r.clip] = r.frames;
		end
		OP_TRIGGER: begin
			if (ticks_since < cooldown_now) begin
				res.status = ST_COOLDOWN;
			end else begin
				res.status = ST_NO_VOICE;
				for (v = 0; v < VOICES; v++)
					if (!voice_live[v] && res.status == ST_NO_VOICE) begin
						voice_live[v] = 1'b1;
						voice_track[v] = r.clip;
						voice_at[v] = '0;
						ticks_since = '0;
						res.status = ST_DONE;
					end
			end
		end
		default: begin
			for (v = 0; v < VOICES; v++)
				if (voice_live[v]) begin
					c = voice_track[v];
					span = clip_span[c];
					if (voice_at[v] < span) begin
						a = SADDR_W'(clip_origin[c] + voice_at[v]);
						w = sample_mem[a];
						sum_l += scaled(w[SMP_W-1:0]);
						sum_r += scaled(w[2*SMP_W-1:SMP_W]);
						voice_at[v] = voice_at[v] + 1'b1;
					end
					// a clip shortened under a playing voice frees it here
					if (voice_at[v] >= span)
						voice_live[v] = 1'b0;
				end
			res.left = clamp16(sum_l);
			res.right = clamp16(sum_r);
			if (ticks_since != COUNT_MAX)
				ticks_since = ticks_since + 1'b1;
		end
		endcase
		for (v = 0; v < VOICES; v++)
			res.busy = res.busy + BUSY_W'(voice_live[v]);
		return res;
	endfunction

	function automatic item_t req_load(input logic [15:0] a, input logic [15:0] l,
			input logic [15:0] rr);
		item_t r;
		r = '0;
		r.op = OP_LOAD;
		r.addr = a;
		r.left = l;
		r.right = rr;
		return r;
	endfunction

	function automatic item_t req_define(input int c, input logic [15:0] s, input int f);
		item_t r;
		r = '0;
		r.op = OP_DEFINE;
		r.clip = CLIP_W'(c);
		r.start = s;
		r.frames = LEN_W'(f);
		return r;
	endfunction

	function automatic item_t req_trigger(input int c);
		item_t r;
		r = '0;
		r.op = OP_TRIGGER;
		r.clip = CLIP_W'(c);
		return r;
	endfunction

	function automatic item_t req_tick();
		item_t r;
		r = '0;
		r.op = OP_TICK;
		return r;
	endfunction

	function automatic mix_t mix_of(input int l, input int rr, input status_t st, input int b);
		mix_t m;
		m.left = SMP_W'(l);
		m.right = SMP_W'(rr);
		m.status = st;
		m.busy = BUSY_W'(b);
		return m;
	endfunction

	function automatic logic [SADDR_W-1:0] pool_address();
		if ($urandom_range(3) == 0)
			return SADDR_W'(16'hFFF0 + $urandom_range(15));
		return SADDR_W'($urandom_range(47));
	endfunction

	function automatic logic [SMP_W-1:0] sample_value();
		case ($urandom_range(9))
		0: return 16'h7FFF;
		1: return 16'h8000;
		2: return 16'hFFFF;
		default: return SMP_W'($urandom);
		endcase
	endfunction

	task automatic note_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_request(input item_t r, output mix_t predicted);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
		in_valid <= 1'b1;
		op <= r.op;
		mem_address <= r.addr;
		load_left <= r.left;
		load_right <= r.right;
		clip_index <= r.clip;
		clip_start <= r.start;
		clip_frames <= r.frames;
		do @(posedge clk); while (!in_ready);
		predicted = mix_step(r);
	endtask

	task automatic write_settings(input logic [CFG_DATA_W-1:0] gain_word,
			input logic [CFG_DATA_W-1:0] cooldown);
		in_valid <= 1'b0;
		while (mix_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_GAIN;
		cfg_data <= gain_word;
		do @(posedge clk); while (!cfg_ready);
		gain_now = gain_word[GAIN_W-1:0];
		cfg_index <= REG_COOLDOWN;
		cfg_data <= cooldown;
		do @(posedge clk); while (!cfg_ready);
		cooldown_now = cooldown;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int count);
		item_t r;
		mix_t  m;
		int    pick;
		int    c;
		int    k;
		int    t;
		int    run;
		bit    ok;
		bit    held;
		repeat (count) begin
			// fields the op ignores carry noise
			r.op = OP_TICK;
			r.addr = SADDR_W'($urandom);
			r.left = SMP_W'($urandom);
			r.right = SMP_W'($urandom);
			r.clip = CLIP_W'($urandom);
			r.start = BASE_W'($urandom);
			r.frames = LEN_W'($urandom_range(65536));
			pick = $urandom_range(99);
			if (pick < 25) begin
				r.op = OP_LOAD;
				if ($urandom_range(99) < 85)
					r.addr = pool_address();
				r.left = sample_value();
				r.right = sample_value();
			end else if (pick < 40) begin
				r.op = OP_DEFINE;
				held = 1'b0;
				for (k = 0; k < VOICES; k++)
					if (voice_live[k] && voice_track[k] == r.clip)
						held = 1'b1;
				// a clip in play only ever gets a range that is fully loaded
				if (held || $urandom_range(3) != 0) begin
					r.start = pool_address();
					t = $urandom_range(8);
					run = 0;
					while (run < t && word_written[SADDR_W'(r.start + run)])
						run++;
					r.frames = LEN_W'(run);
				end
			end else if (pick < 58) begin
				ok = 1'b0;
				for (t = 0; t < 8 && !ok; t++) begin
					c = $urandom_range(CLIPS - 1);
					ok = 1'b1;
					for (k = 0; k < int'(clip_span[c]) && ok; k++)
						ok = word_written[SADDR_W'(clip_origin[c] + k)];
				end
				if (ok) begin
					r.op = OP_TRIGGER;
					r.clip = CLIP_W'(c);
				end
			end
			send_request(r, m);
			mix_due.push_back(m);
		end
	endtask

	always @(posedge clk) begin : result_check
		mix_t want;
		if (out_valid && out_ready) begin
			if (mix_due.size() == 0) begin
				note_mismatch("result with no request pending", mix_left, 0);
			end else begin
				want = mix_due.pop_front();
				if (mix_left !== want.left)
					note_mismatch("mix_left", mix_left, want.left);
				if (mix_right !== want.right)
					note_mismatch("mix_right", mix_right, want.right);
				if (status !== want.status)
					note_mismatch("status", status, want.status);
				if (busy_voices !== want.busy)
					note_mismatch("busy_voices", busy_voices, want.busy);
			end
		end
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** sample_voice_mixer: FAILED **");
		$finish;
	end

	initial begin : stimulus
		row_t plan [$];
		mix_t m;
		for (int i = 0; i < SAMPLE_DEPTH; i++) begin
			sample_mem[i] = '0;
			word_written[i] = 1'b0;
		end
		for (int i = 0; i < CLIPS; i++) begin
			clip_origin[i] = '0;
			clip_span[i] = '0;
		end
		for (int i = 0; i < VOICES; i++) begin
			voice_live[i] = 1'b0;
			voice_track[i] = '0;
			voice_at[i] = '0;
		end
		ticks_since = COUNT_MAX;
		gain_now = GAIN_RST;
		cooldown_now = COOLDOWN_RST;

		plan = '{
			// reset settings: gain 205, long cooldown
			'{req_load(16'h0000, 16'h7FFF, 16'h8000), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			'{req_load(16'h0001, 16'h8000, 16'h7FFF), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			'{req_load(16'hFFFF, 16'h0001, 16'hFFFF), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			'{req_load(16'h0002, 16'hFFFF, 16'h0001), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			'{req_define(0, 16'h0000, 3), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			// wraps from the top of sample memory to the bottom
			'{req_define(127, 16'hFFFF, 2), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			'{req_tick(), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			'{req_trigger(0), 1'b1, mix_of(0, 0, ST_DONE, 1)},
			'{req_trigger(127), 1'b1, mix_of(0, 0, ST_COOLDOWN, 1)},
			'{req_tick(), 1'b0, '0},
			'{req_tick(), 1'b0, '0},
			'{req_tick(), 1'b0, '0},
			// full gain, no cooldown
			'{req_trigger(0), 1'b1, mix_of(0, 0, ST_DONE, 1)},
			'{req_trigger(127), 1'b1, mix_of(0, 0, ST_DONE, 2)},
			'{req_trigger(5), 1'b1, mix_of(0, 0, ST_NO_VOICE, 2)},
			'{req_tick(), 1'b1, mix_of(32767, -32768, ST_DONE, 2)},
			'{req_tick(), 1'b0, '0},
			// shorten the clip under the playing voice
			'{req_define(0, 16'h0000, 1), 1'b1, mix_of(0, 0, ST_DONE, 1)},
			'{req_tick(), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			'{req_define(3, 16'd40, 0), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			'{req_trigger(3), 1'b1, mix_of(0, 0, ST_DONE, 1)},
			'{req_tick(), 1'b1, mix_of(0, 0, ST_DONE, 0)},
			// longest clip, never played
			'{req_define(126, 16'hFFFF, 65536), 1'b1, mix_of(0, 0, ST_DONE, 0)}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (i == FULL_GAIN_ROW)
				write_settings(16'h03FF, 16'h0000);
			send_request(plan[i].req, m);
			mix_due.push_back(plan[i].typed ? plan[i].want : m);
		end

		write_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(3)));
		run_phase(110);
		idle_pct = 0;
		write_settings(16'd256, 16'd1);
		run_phase(100);
		idle_pct = 7;
		write_settings(16'd0, 16'd2);
		run_phase(40);
		write_settings(16'h03FF, 16'hFFFF);
		run_phase(30);
		write_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(5)));
		run_phase(110);

		in_valid <= 1'b0;
		while (mix_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** sample_voice_mixer: PASSED **");
		else
			$display("** sample_voice_mixer: FAILED **");
		$finish;
	end

endmodule
